/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked on aclk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/cki_pkg.sv */
package cki_pkg;

    localparam int MAX_KEYS       = 16;
    localparam int HOUR_FRAC_BITS = 16;
    localparam int HOUR_W         = HOUR_FRAC_BITS + 5;
    localparam int LOW_W          = HOUR_FRAC_BITS + 3;
    localparam int QW             = 32 - LOW_W;
    localparam int UW             = ((QW + 3) / 2) * 2;
    localparam int NDIG           = UW / 2;
    localparam int DAY_UNITS      = 24 << HOUR_FRAC_BITS;
    localparam int CNT_W          = $clog2(MAX_KEYS + 1);
    localparam int IDX_W          = $clog2(MAX_KEYS);
    localparam int DIFF_W         = 33;
    localparam int PROD_W         = DIFF_W + HOUR_W;
    localparam int DCNT_W         = $clog2(DIFF_W);

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_EVAL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_REPLACED = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_FALLBACK_R = 2'd0,
        REG_FALLBACK_G = 2'd1,
        REG_FALLBACK_B = 2'd2,
        REG_MATCH_TOL  = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SET_RD,
        S_SET_CHK,
        S_SET_END,
        S_SHIFT_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_REM_CHK,
        S_REM_RD,
        S_REM_WR,
        S_ONE_RD,
        S_ONE_CAP,
        S_EV_RD,
        S_EV_CHK,
        S_LO_RD,
        S_LO_CAP,
        S_HI_CAP,
        S_SPAN,
        S_ZERO,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_ADD,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [31:0]       val_r;
        logic [31:0]       val_g;
        logic [31:0]       val_b;
    } key_t;

    // hour modulo one day: the day is 3 << LOW_W, so only the upper part needs a mod 3
    function automatic logic [HOUR_W-1:0] wrap_hour(input logic [31:0] h);
        logic [UW-1:0] u;
        logic [5:0]    s1;
        logic [3:0]    s2;
        logic [1:0]    m;
        u  = UW'({{(UW - QW){h[31]}}, h[31:LOW_W]}) + UW'(3 << (QW - 1));
        s1 = '0;
        // 4 is 1 mod 3, so base-4 digit sums keep the residue
        for (int k = 0; k < NDIG; k++) begin
            s1 = s1 + 6'(u[2*k +: 2]);
        end
        s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
        if (s2 >= 4'd6) begin
            m = 2'(s2 - 4'd6);
        end else if (s2 >= 4'd3) begin
            m = 2'(s2 - 4'd3);
        end else begin
            m = s2[1:0];
        end
        return {m, h[LOW_W-1:0]};
    endfunction

endpackage

/* hw/rtl/cyclic_keyframe_interpolator.sv */
// clear resets the count; set scans for a match, else shifts the keys from the insert slot up;
// remove moves the later keys down; evaluate of two or more keys scans them all, then divides per component
// one transaction at a time, as s_ready is high only in idle; the key memory (one read and
// one write a cycle) and the one bit-serial divider serve all three components
// reset: aresetn synchronous, active low; key count cleared, fallbacks zero,
// match tolerance 7; key memory is not cleared
module cyclic_keyframe_interpolator
    import cki_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_hour,
    input  logic [31:0] s_value_r,
    input  logic [31:0] s_value_g,
    input  logic [31:0] s_value_b,
    input  logic [7:0]  s_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_r,
    output logic [31:0] m_result_g,
    output logic [31:0] m_result_b,
    output logic [1:0]  m_status,
    output logic [4:0]  m_key_count
);

    fsm_t state_reg, state_next;

    logic [31:0] fallback_r_reg, fallback_g_reg, fallback_b_reg;
    logic [7:0]  match_tol_reg;

    op_t              op_reg;
    logic [HOUR_W-1:0] w_reg;
    logic [31:0]      vr_reg, vg_reg, vb_reg;
    logic [CNT_W-1:0] count_reg, n_new_reg;
    logic [CNT_W-1:0] i_reg, at_reg;
    logic             found_reg;
    logic [IDX_W-1:0] lo_reg;
    logic             wrap_reg;
    logic [HOUR_W-1:0] start_reg, end_reg, span_reg, num_reg;
    logic [31:0]      a_val_reg [3];
    logic [31:0]      b_val_reg [3];
    logic [31:0]      res_reg   [3];
    logic [1:0]       comp_reg;
    logic [DIFF_W-1:0] mag_reg;
    logic             neg_reg;
    logic [HOUR_W-1:0] rem_reg;
    logic [DIFF_W-1:0] quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    status_t          status_reg;

    logic        m_valid_reg;
    logic [31:0] m_r_reg, m_g_reg, m_b_reg;
    logic [1:0]  m_status_reg;
    logic [4:0]  m_count_reg;

    key_t             mem [MAX_KEYS];
    key_t             mem_rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    key_t             mem_wdata;

    logic             s_fire;
    logic             out_free;
    logic [CNT_W:0]   i_inc;
    logic             more_keys;
    logic [HOUR_W-1:0] hdiff;
    logic             hit;
    logic [IDX_W-1:0] hi_idx;
    logic [HOUR_W:0]  end_x, pos_x, span_x;
    logic signed [HOUR_W+1:0] num_x;
    logic signed [DIFF_W-1:0] diff;
    logic [PROD_W-1:0] prod;
    logic [HOUR_W:0]  div_t;
    logic             div_ge;
    logic [DIFF_W:0]  q_signed;
    logic [DIFF_W:0]  sum_x;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign i_inc     = (CNT_W + 1)'(i_reg) + 1'b1;
    assign more_keys = i_inc < (CNT_W + 1)'(count_reg);
    assign hdiff     = (mem_rdata_reg.hour >= w_reg) ? mem_rdata_reg.hour - w_reg
                                                     : w_reg - mem_rdata_reg.hour;
    assign hit       = hdiff < HOUR_W'(match_tol_reg);
    assign hi_idx    = (CNT_W'(lo_reg) == count_reg - 1'b1) ? '0 : lo_reg + 1'b1;

    // segment geometry; the midnight segment moves its end one day later
    assign end_x  = wrap_reg ? (HOUR_W + 1)'(end_reg) + (HOUR_W + 1)'(DAY_UNITS)
                             : (HOUR_W + 1)'(end_reg);
    assign pos_x  = (wrap_reg && (w_reg < start_reg))
                  ? (HOUR_W + 1)'(w_reg) + (HOUR_W + 1)'(DAY_UNITS)
                  : (HOUR_W + 1)'(w_reg);
    assign span_x = end_x - (HOUR_W + 1)'(start_reg);
    assign num_x  = $signed({1'b0, pos_x}) - $signed((HOUR_W + 2)'(start_reg));

    assign diff   = $signed({b_val_reg[comp_reg][31], b_val_reg[comp_reg]})
                  - $signed({a_val_reg[comp_reg][31], a_val_reg[comp_reg]});
    assign prod   = PROD_W'(mag_reg) * PROD_W'(num_reg);
    assign div_t  = {rem_reg, quo_reg[DIFF_W-1]};
    assign div_ge = div_t >= (HOUR_W + 1)'(span_reg);
    assign q_signed = neg_reg ? (DIFF_W + 1)'(0) - {1'b0, quo_reg} : {1'b0, quo_reg};
    assign sum_x  = {{2{a_val_reg[comp_reg][31]}}, a_val_reg[comp_reg]} + q_signed;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    unique case (op_t'(s_operation))
                        OP_SET:    state_next = (count_reg == '0) ? S_SET_END : S_SET_RD;
                        OP_REMOVE: state_next = (16'(s_index) >= 16'(count_reg)) ? S_DONE
                                                                               : S_REM_CHK;
                        OP_CLEAR:  state_next = S_DONE;
                        OP_EVAL: begin
                            if (count_reg == '0) begin
                                state_next = S_DONE;
                            end else if (count_reg == CNT_W'(1)) begin
                                state_next = S_ONE_RD;
                            end else begin
                                state_next = S_EV_RD;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SET_RD:    state_next = S_SET_CHK;
            S_SET_CHK: begin
                if (hit) begin
                    state_next = S_DONE;
                end else if (!more_keys) begin
                    state_next = S_SET_END;
                end else begin
                    state_next = S_SET_RD;
                end
            end
            S_SET_END:   state_next = (32'(count_reg) >= MAX_KEYS) ? S_DONE : S_SHIFT_CHK;
            S_SHIFT_CHK: state_next = (i_reg > at_reg) ? S_SHIFT_RD : S_INS_WR;
            S_SHIFT_RD:  state_next = S_SHIFT_WR;
            S_SHIFT_WR:  state_next = S_SHIFT_CHK;
            S_INS_WR:    state_next = S_DONE;
            S_REM_CHK:   state_next = more_keys ? S_REM_RD : S_DONE;
            S_REM_RD:    state_next = S_REM_WR;
            S_REM_WR:    state_next = S_REM_CHK;
            S_ONE_RD:    state_next = S_ONE_CAP;
            S_ONE_CAP:   state_next = S_DONE;
            S_EV_RD:     state_next = S_EV_CHK;
            S_EV_CHK:    state_next = more_keys ? S_EV_RD : S_LO_RD;
            S_LO_RD:     state_next = S_LO_CAP;
            S_LO_CAP:    state_next = S_HI_CAP;
            S_HI_CAP:    state_next = S_SPAN;
            S_SPAN:      state_next = (span_x == '0) ? S_ZERO : S_DIFF;
            S_ZERO:      state_next = S_DONE;
            S_DIFF:      state_next = S_MUL;
            S_MUL:       state_next = S_DIV;
            S_DIV:       state_next = (dcnt_reg == DCNT_W'(DIFF_W - 1)) ? S_ADD : S_DIV;
            S_ADD:       state_next = (comp_reg == 2'd2) ? S_DONE : S_DIFF;
            S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // key memory control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = i_reg[IDX_W-1:0];
        mem_wdata = mem_rdata_reg;
        mem_raddr = i_reg[IDX_W-1:0];
        unique case (state_reg)
            S_SET_CHK: begin
                mem_we    = hit;
                mem_wdata = '{hour: mem_rdata_reg.hour, val_r: vr_reg,
                              val_g: vg_reg, val_b: vb_reg};
            end
            S_SHIFT_RD: mem_raddr = IDX_W'(i_reg - 1'b1);
            S_SHIFT_WR: mem_we = 1'b1;
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = at_reg[IDX_W-1:0];
                mem_wdata = '{hour: w_reg, val_r: vr_reg, val_g: vg_reg, val_b: vb_reg};
            end
            S_REM_RD:  mem_raddr = IDX_W'(i_inc);
            S_REM_WR:  mem_we = 1'b1;
            S_ONE_RD:  mem_raddr = '0;
            S_LO_RD:   mem_raddr = lo_reg;
            S_LO_CAP:  mem_raddr = hi_idx;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fallback_r_reg <= '0;
            fallback_g_reg <= '0;
            fallback_b_reg <= '0;
            match_tol_reg  <= 8'd7;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FALLBACK_R: fallback_r_reg <= cfg_wdata;
                REG_FALLBACK_G: fallback_g_reg <= cfg_wdata;
                REG_FALLBACK_B: fallback_b_reg <= cfg_wdata;
                REG_MATCH_TOL:  match_tol_reg  <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                count_reg   <= n_new_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                op_reg     <= op_t'(s_operation);
                w_reg      <= wrap_hour(s_hour);
                vr_reg     <= s_value_r;
                vg_reg     <= s_value_g;
                vb_reg     <= s_value_b;
                i_reg      <= (op_t'(s_operation) == OP_REMOVE) ? CNT_W'(s_index) : '0;
                at_reg     <= count_reg;
                found_reg  <= 1'b0;
                lo_reg     <= IDX_W'(count_reg - 1'b1);
                comp_reg   <= '0;
                n_new_reg  <= (op_t'(s_operation) == OP_CLEAR) ? '0 : count_reg;
                status_reg <= (op_t'(s_operation) == OP_REMOVE
                               && 16'(s_index) >= 16'(count_reg)) ? STAT_RANGE : STAT_OK;
                res_reg[0] <= (op_t'(s_operation) == OP_EVAL) ? fallback_r_reg : '0;
                res_reg[1] <= (op_t'(s_operation) == OP_EVAL) ? fallback_g_reg : '0;
                res_reg[2] <= (op_t'(s_operation) == OP_EVAL) ? fallback_b_reg : '0;
            end
            S_SET_CHK: begin
                if (hit) begin
                    status_reg <= STAT_REPLACED;
                end else begin
                    // first key not below the new hour marks the insert slot
                    if (!found_reg && mem_rdata_reg.hour >= w_reg) begin
                        found_reg <= 1'b1;
                        at_reg    <= i_reg;
                    end
                    i_reg <= CNT_W'(i_inc);
                end
            end
            S_SET_END: begin
                i_reg <= count_reg;
                if (32'(count_reg) >= MAX_KEYS) begin
                    status_reg <= STAT_FULL;
                end
            end
            S_SHIFT_WR: i_reg <= i_reg - 1'b1;
            S_INS_WR:   n_new_reg <= count_reg + 1'b1;
            S_REM_CHK: begin
                if (!more_keys) begin
                    n_new_reg <= count_reg - 1'b1;
                end
            end
            S_REM_WR:   i_reg <= CNT_W'(i_inc);
            S_ONE_CAP: begin
                res_reg[0] <= mem_rdata_reg.val_r;
                res_reg[1] <= mem_rdata_reg.val_g;
                res_reg[2] <= mem_rdata_reg.val_b;
            end
            S_EV_CHK: begin
                if (mem_rdata_reg.hour <= w_reg) begin
                    lo_reg <= i_reg[IDX_W-1:0];
                end
                i_reg <= CNT_W'(i_inc);
            end
            S_LO_CAP: begin
                start_reg    <= mem_rdata_reg.hour;
                a_val_reg[0] <= mem_rdata_reg.val_r;
                a_val_reg[1] <= mem_rdata_reg.val_g;
                a_val_reg[2] <= mem_rdata_reg.val_b;
                wrap_reg     <= (CNT_W'(lo_reg) == count_reg - 1'b1);
            end
            S_HI_CAP: begin
                end_reg      <= mem_rdata_reg.hour;
                b_val_reg[0] <= mem_rdata_reg.val_r;
                b_val_reg[1] <= mem_rdata_reg.val_g;
                b_val_reg[2] <= mem_rdata_reg.val_b;
            end
            S_SPAN: begin
                span_reg <= HOUR_W'(span_x);
                if (num_x < 0) begin
                    num_reg <= '0;
                end else if (num_x > $signed({1'b0, span_x})) begin
                    num_reg <= HOUR_W'(span_x);
                end else begin
                    num_reg <= HOUR_W'(num_x);
                end
            end
            S_ZERO: begin
                res_reg[0] <= a_val_reg[0];
                res_reg[1] <= a_val_reg[1];
                res_reg[2] <= a_val_reg[2];
            end
            S_DIFF: begin
                neg_reg <= diff[DIFF_W-1];
                mag_reg <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            end
            S_MUL: begin
                rem_reg  <= prod[PROD_W-1:DIFF_W];
                quo_reg  <= prod[DIFF_W-1:0];
                dcnt_reg <= '0;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                rem_reg  <= div_ge ? HOUR_W'(div_t - (HOUR_W + 1)'(span_reg))
                                   : div_t[HOUR_W-1:0];
                quo_reg  <= {quo_reg[DIFF_W-2:0], div_ge};
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            S_ADD: begin
                res_reg[comp_reg] <= sum_x[31:0];
                comp_reg          <= comp_reg + 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    m_r_reg      <= res_reg[0];
                    m_g_reg      <= res_reg[1];
                    m_b_reg      <= res_reg[2];
                    m_status_reg <= status_reg;
                    m_count_reg  <= 5'(n_new_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_result_r  = m_r_reg;
    assign m_result_g  = m_g_reg;
    assign m_result_b  = m_b_reg;
    assign m_status    = m_status_reg;
    assign m_key_count = m_count_reg;

    `include "assert_macros.svh"

    `ASSERT_NOW(a_count_bound, 1'b1, 32'(count_reg) <= MAX_KEYS)
    `ASSERT_NOW(a_div_span, state_reg == S_DIV, span_reg != '0 && rem_reg < span_reg)
    `ASSERT_NEXT(a_clear_empty, s_fire && s_operation == OP_CLEAR, n_new_reg == '0)
    `ASSERT_NOW(a_eval_status, state_reg == S_DONE && op_reg == OP_EVAL, status_reg == STAT_OK)

endmodule

/* bench/cyclic_keyframe_interpolator_tb.sv */
module cyclic_keyframe_interpolator_tb;
    import cki_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DAY = 24 * 65536;
    localparam int TABLE_DEPTH = 16;
    localparam int RANDOM_ITEMS = 1150;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        op_t         op;
        logic [31:0] hour;
        logic [31:0] vr;
        logic [31:0] vg;
        logic [31:0] vb;
        logic [7:0]  idx;
    } key_op_t;

    typedef struct {
        logic [31:0] rr;
        logic [31:0] rg;
        logic [31:0] rb;
        status_t     st;
        logic [4:0]  cnt;
    } key_result_t;

    typedef struct {
        key_op_t     item;
        bit          typed;
        key_result_t res;
    } table_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [31:0] s_hour = '0;
    logic [31:0] s_value_r = '0;
    logic [31:0] s_value_g = '0;
    logic [31:0] s_value_b = '0;
    logic [7:0]  s_index = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_result_r;
    logic [31:0] m_result_g;
    logic [31:0] m_result_b;
    logic [1:0]  m_status;
    logic [4:0]  m_key_count;

    cyclic_keyframe_interpolator uut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // predictor state
    longint      kh [TABLE_DEPTH];
    logic [31:0] kr [TABLE_DEPTH];
    logic [31:0] kg [TABLE_DEPTH];
    logic [31:0] kb [TABLE_DEPTH];
    int          nkeys = 0;
    logic [31:0] fb_r = 0, fb_g = 0, fb_b = 0;
    int          tol = 7;

    key_result_t expected_results[$];
    int          errors = 0;
    longint      cycles = 0;

    function automatic longint wrap_day(logic [31:0] h);
        longint r;
        r = longint'($signed(h)) % DAY;
        return r < 0 ? r + DAY : r;
    endfunction

    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                          longint num, longint span);
        longint av, bv;
        av = longint'($signed(a));
        bv = longint'($signed(b));
        if (span <= 0) return a;
        return 32'(av + ((bv - av) * num) / span);
    endfunction

    task automatic keyframe_apply(input key_op_t it, output key_result_t r);
        longint w, start, stop, pos, num, span, d;
        int lo, hi, at;
        bit done;
        r = '{32'd0, 32'd0, 32'd0, STAT_OK, 5'd0};
        w = wrap_day(it.hour);
        done = 0;
        case (it.op)
            OP_SET: begin
                for (int i = 0; i < nkeys && !done; i++) begin
                    d = kh[i] - w;
                    if (d < 0) d = -d;
                    if (d < tol) begin
                        kr[i] = it.vr; kg[i] = it.vg; kb[i] = it.vb;
                        r.st = STAT_REPLACED;
                        done = 1;
                    end
                end
                if (!done) begin
                    if (nkeys >= TABLE_DEPTH) begin
                        r.st = STAT_FULL;
                    end else begin
                        at = 0;
                        while (at < nkeys && kh[at] < w) at++;
                        for (int i = nkeys; i > at; i--) begin
                            kh[i] = kh[i-1]; kr[i] = kr[i-1];
                            kg[i] = kg[i-1]; kb[i] = kb[i-1];
                        end
                        kh[at] = w; kr[at] = it.vr; kg[at] = it.vg; kb[at] = it.vb;
                        nkeys++;
                    end
                end
            end
            OP_REMOVE: begin
                if (it.idx < nkeys) begin
                    for (int i = it.idx; i + 1 < nkeys; i++) begin
                        kh[i] = kh[i+1]; kr[i] = kr[i+1];
                        kg[i] = kg[i+1]; kb[i] = kb[i+1];
                    end
                    nkeys--;
                end else begin
                    r.st = STAT_RANGE;
                end
            end
            OP_CLEAR: nkeys = 0;
            default: begin
                if (nkeys == 0) begin
                    r.rr = fb_r; r.rg = fb_g; r.rb = fb_b;
                end else if (nkeys == 1) begin
                    r.rr = kr[0]; r.rg = kg[0]; r.rb = kb[0];
                end else begin
                    lo = nkeys - 1;
                    for (int i = 0; i < nkeys; i++) if (kh[i] <= w) lo = i;
                    hi = (lo == nkeys - 1) ? 0 : lo + 1;
                    start = kh[lo];
                    stop = kh[hi];
                    pos = w;
                    if (hi == 0) begin
                        stop += DAY;
                        if (pos < start) pos += DAY;
                    end
                    span = stop - start;
                    num = pos - start;
                    if (num < 0) num = 0;
                    if (num > span) num = span;
                    r.rr = blend(kr[lo], kr[hi], num, span);
                    r.rg = blend(kg[lo], kg[hi], num, span);
                    r.rb = blend(kb[lo], kb[hi], num, span);
                end
            end
        endcase
        r.cnt = 5'(nkeys);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // result side
    initial begin : sink
        key_result_t e;
        int wait_n;
        @(posedge aclk iff aresetn);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_n > 0) begin
                m_ready <= 0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk iff m_valid);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", 32'(m_key_count), 32'd0);
            end else begin
                e = expected_results.pop_front();
                if (m_result_r !== e.rr) report_mismatch("result_r", m_result_r, e.rr);
                if (m_result_g !== e.rg) report_mismatch("result_g", m_result_g, e.rg);
                if (m_result_b !== e.rb) report_mismatch("result_b", m_result_b, e.rb);
                if (m_status !== e.st)
                    report_mismatch("status", 32'(m_status), 32'(e.st));
                if (m_key_count !== e.cnt)
                    report_mismatch("key_count", 32'(m_key_count), 32'(e.cnt));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("cyclic_keyframe_interpolator: mismatch");
            $finish;
        end
    end

    task automatic send_op(input key_op_t it, input bit typed, input key_result_t want,
                           input bit gaps);
        key_result_t p;
        int wait_n;
        wait_n = gaps ? $urandom_range(0, 7) : 0;
        if (wait_n > 0) begin
            s_valid <= 0;
            repeat (wait_n) @(posedge aclk);
        end
        s_valid <= 1;
        s_operation <= it.op;
        s_hour <= it.hour;
        s_value_r <= it.vr;
        s_value_g <= it.vg;
        s_value_b <= it.vb;
        s_index <= it.idx;
        @(posedge aclk iff s_ready);
        keyframe_apply(it, p);
        if (typed && (p.rr !== want.rr || p.rg !== want.rg || p.rb !== want.rb ||
                      p.st !== want.st || p.cnt !== want.cnt)) begin
            $display("%0t: directed row disagrees with predictor", $realtime);
            errors++;
        end
        expected_results.push_back(typed ? want : p);
    endtask

    task automatic write_reg(input cfg_reg_t a, input logic [31:0] v);
        cfg_we <= 1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
        case (a)
            REG_FALLBACK_R: fb_r = v;
            REG_FALLBACK_G: fb_g = v;
            REG_FALLBACK_B: fb_b = v;
            default: tol = v[7:0];
        endcase
    endtask

    task automatic drain();
        s_valid <= 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic key_op_t mk(op_t op, logic [31:0] h, logic [31:0] r,
                                   logic [31:0] g, logic [31:0] b, logic [7:0] i);
        key_op_t k;
        k.op = op; k.hour = h; k.vr = r; k.vg = g; k.vb = b; k.idx = i;
        return k;
    endfunction

    function automatic logic [31:0] rand_hour();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'(-$urandom_range(0, 2 * 24 * 65536));
            2: return {27'd0, 5'd0} + $urandom_range(0, 64) * 65536 + $urandom_range(0, 7);
            default: return $urandom_range(0, 24 * 65536 - 1);
        endcase
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    initial begin : stim
        table_row_t rows[$];
        key_result_t z;
        key_op_t it;
        int sel, items;
        z = '{32'd0, 32'd0, 32'd0, STAT_OK, 5'd0};
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            kh[i] = 0; kr[i] = 0; kg[i] = 0; kb[i] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        write_reg(REG_FALLBACK_R, 32'h7fffffff);
        write_reg(REG_FALLBACK_G, 32'h80000000);
        write_reg(REG_FALLBACK_B, 32'h00010000);
        // empty table evaluates to the fallbacks
        rows.push_back('{mk(OP_EVAL, 32'h0, 0, 0, 0, 0), 1,
                         '{32'h7fffffff, 32'h80000000, 32'h00010000, STAT_OK, 5'd0}});
        rows.push_back('{mk(OP_REMOVE, 0, 0, 0, 0, 8'hff), 1,
                         '{0, 0, 0, STAT_RANGE, 5'd0}});
        rows.push_back('{mk(OP_SET, 32'h80000000, 32'h7fffffff, 32'h80000000,
                         32'hffffffff, 8'hff), 1, '{0, 0, 0, STAT_OK, 5'd1}});
        rows.push_back('{mk(OP_EVAL, 32'h7fffffff, 0, 0, 0, 0), 1,
                         '{32'h7fffffff, 32'h80000000, 32'hffffffff, STAT_OK, 5'd1}});
        rows.push_back('{mk(OP_SET, 32'h00170000, 32'h00010000, 0, 32'h80000000, 0), 0, z});
        rows.push_back('{mk(OP_SET, 32'h00050000, 32'hffff0000, 32'h7fffffff, 0, 0), 0, z});
        // within tolerance of the key above, so it replaces
        rows.push_back('{mk(OP_SET, 32'h00050003, 32'h00020000, 32'h1, 32'h2, 0), 0, z});
        rows.push_back('{mk(OP_EVAL, 32'h00000000, 0, 0, 0, 0), 0, z});
        rows.push_back('{mk(OP_EVAL, 32'h00178000, 0, 0, 0, 0), 0, z});
        rows.push_back('{mk(OP_EVAL, 32'h000a0000, 0, 0, 0, 0), 0, z});
        rows.push_back('{mk(OP_EVAL, 32'hffff0000, 0, 0, 0, 0), 0, z});
        rows.push_back('{mk(OP_EVAL, 32'h80000000, 0, 0, 0, 0), 0, z});
        rows.push_back('{mk(OP_REMOVE, 0, 0, 0, 0, 8'd3), 1, '{0, 0, 0, STAT_RANGE, 5'd3}});
        rows.push_back('{mk(OP_REMOVE, 0, 0, 0, 0, 8'd1), 0, z});
        rows.push_back('{mk(OP_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                         32'hffffffff, 8'hff), 1, '{0, 0, 0, STAT_OK, 5'd0}});
        foreach (rows[i]) send_op(rows[i].item, rows[i].typed, rows[i].res, 1);
        drain();
        // zero tolerance: duplicate hours, then fill the table
        write_reg(REG_MATCH_TOL, 0);
        send_op(mk(OP_SET, 32'h00030000, 32'h100, 0, 0, 0), 0, z, 0);
        send_op(mk(OP_SET, 32'h00030000, 32'h200, 0, 0, 0), 0, z, 0);
        send_op(mk(OP_EVAL, 32'h00030000, 0, 0, 0, 0), 0, z, 0);
        for (int i = 0; i < 16; i++)
            send_op(mk(OP_SET, rand_hour(), rand_val(), rand_val(), rand_val(), 0), 0, z, 0);
        send_op(mk(OP_EVAL, rand_hour(), 0, 0, 0, 0), 0, z, 1);
        drain();
        write_reg(REG_MATCH_TOL, 255);
        write_reg(REG_FALLBACK_R, 0);
        write_reg(REG_FALLBACK_G, 32'hffffffff);
        write_reg(REG_FALLBACK_B, 32'h80000000);
        items = 0;
        while (items < RANDOM_ITEMS) begin
            if (items % 300 == 150) begin
                drain();
                write_reg(REG_MATCH_TOL, $urandom_range(0, 255));
                write_reg(cfg_reg_t'($urandom_range(0, 2)), rand_val());
            end
            sel = $urandom_range(0, 99);
            if (sel < 40)
                it = mk(OP_SET, rand_hour(), rand_val(), rand_val(), rand_val(),
                        8'($urandom()));
            else if (sel < 52)
                it = mk(OP_REMOVE, $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom_range(0, 3) == 0 ? 8'($urandom()) :
                        8'($urandom_range(0, 16)));
            else if (sel < 55)
                it = mk(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                        8'($urandom()));
            else
                it = mk(OP_EVAL, rand_hour(), $urandom(), $urandom(), $urandom(),
                        8'($urandom()));
            send_op(it, 0, z, (items / 100) % 3 != 0);
            items++;
        end
        drain();
        if (errors == 0) begin
            $display("cyclic_keyframe_interpolator: match");
        end else begin
            $display("cyclic_keyframe_interpolator: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/cki_pkg.sv
hw/rtl/cyclic_keyframe_interpolator.sv
bench/cyclic_keyframe_interpolator_tb.sv
